// File: design/guarded_transition_table_macros.svh
`ifndef GUARDED_TRANSITION_TABLE_MACROS_SVH
`define GUARDED_TRANSITION_TABLE_MACROS_SVH

// implication in the same cycle, checked on every rising edge outside reset
`define GTT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtt checker: property failed");

// implication in the next cycle, checked on every rising edge outside reset
`define GTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gtt checker: property failed");

`endif

// File: design/gtt_pkg.sv
// ----------------------------------------------------------------------------
// gtt_pkg
// Types, widths and codes shared by the guarded transition table modules.
// ----------------------------------------------------------------------------
package gtt_pkg;

  // default number of rows in the permission matrix
  localparam int unsigned MAX_STATES_DEF = 32;

  // field widths
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned STATE_W = 5;
  localparam int unsigned ROW_W   = 32;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned TOT_W   = 32;
  localparam int unsigned STAT_W  = 2;

  // configuration port
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_STATE_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_STATE = 1'b1;

  localparam logic [CNT_W-1:0]   STATE_COUNT_RST   = 6'd32;
  localparam logic [STATE_W-1:0] INITIAL_STATE_RST = 5'd0;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 3'd0,
    CMD_RESTART = 3'd1,
    CMD_GO      = 3'd2,
    CMD_FORCE   = 3'd3,
    CMD_QUERY   = 3'd4
  } gtt_cmd_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_REFUSED = 2'd2
  } gtt_status_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_QROW  = 2'd2,
    S_QPICK = 2'd3
  } gtt_state_e;

  // matrix read address select
  typedef enum logic [1:0] {
    RD_CUR  = 2'd0,
    RD_FROM = 2'd1,
    RD_NODE = 2'd2
  } gtt_rd_sel_e;

  // input item
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [ROW_W-1:0]   row_bits;
  } gtt_item_t;

  // result item
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [STATE_W-1:0] current_state;
    logic [TOT_W-1:0]   transition_total;
    logic [TOT_W-1:0]   refusal_total;
    logic               may_go;
    logic [ROW_W-1:0]   row_mask;
    logic               is_terminal;
    logic               reachable_flag;
  } gtt_result_t;

  // controller to datapath commands
  typedef struct packed {
    logic        latch;
    gtt_rd_sel_e rd_sel;
    logic        exec;
    logic        q_init;
    logic        q_step;
    logic        q_pick;
    logic        emit;
  } gtt_ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic query_ok;
    logic pending_empty;
  } gtt_stat_t;

endpackage

// File: design/guarded_transition_table.sv
// ----------------------------------------------------------------------------
// guarded_transition_table: takes a new command only while busy is low. The
// result strobe is registered from the EXEC state, or for a query from the last
// QPICK of the row-by-row search over the single matrix read port. Reset clears
// the matrix at once through per-row valid flags, no clear pass.
// ----------------------------------------------------------------------------
module guarded_transition_table #(
  parameter int unsigned MAX_STATES = gtt_pkg::MAX_STATES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  gtt_pkg::gtt_item_t            item_i,
  output gtt_pkg::gtt_result_t          res_o,
  output logic                          done_o,
  input  logic                          cfg_we_i,
  input  logic [gtt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gtt_pkg::CFG_W-1:0]     cfg_wdata_i
);

  gtt_pkg::gtt_ctrl_t ctrl;
  gtt_pkg::gtt_stat_t stat;

  // sequencer
  gtt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // matrix, state and counters
  gtt_datapath #(
    .MAX_STATES (MAX_STATES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .res_o       (res_o),
    .done_o      (done_o)
  );

endmodule

// File: design/gtt_ctrl.sv
// ----------------------------------------------------------------------------
// gtt_ctrl
// Sequencer for the guarded transition table: execute one command, or walk
// the reachability search row by row for a query.
// ----------------------------------------------------------------------------
module gtt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  gtt_pkg::gtt_stat_t stat_i,
  output gtt_pkg::gtt_ctrl_t ctrl_o
);

  gtt_pkg::gtt_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gtt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gtt_pkg::S_IDLE: begin
        if (start) state_d = gtt_pkg::S_EXEC;
      end
      gtt_pkg::S_EXEC: begin
        state_d = stat_i.query_ok ? gtt_pkg::S_QROW : gtt_pkg::S_IDLE;
      end
      gtt_pkg::S_QROW: begin
        state_d = gtt_pkg::S_QPICK;
      end
      gtt_pkg::S_QPICK: begin
        state_d = stat_i.pending_empty ? gtt_pkg::S_IDLE : gtt_pkg::S_QROW;
      end
      default: begin
        state_d = gtt_pkg::S_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    ctrl_o        = '0;
    ctrl_o.rd_sel = gtt_pkg::RD_CUR;
    busy          = 1'b1;
    case (state_q)
      gtt_pkg::S_IDLE: begin
        busy         = 1'b0;
        ctrl_o.latch = start;
      end
      gtt_pkg::S_EXEC: begin
        ctrl_o.exec   = 1'b1;
        ctrl_o.rd_sel = gtt_pkg::RD_FROM;
        ctrl_o.q_init = stat_i.query_ok;
        ctrl_o.emit   = !stat_i.query_ok;
      end
      gtt_pkg::S_QROW: begin
        ctrl_o.q_step = 1'b1;
      end
      gtt_pkg::S_QPICK: begin
        ctrl_o.rd_sel = gtt_pkg::RD_NODE;
        ctrl_o.q_pick = 1'b1;
        ctrl_o.emit   = stat_i.pending_empty;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// File: design/gtt_datapath.sv
// ----------------------------------------------------------------------------
// gtt_datapath
// Permission matrix, current state, counters, configuration registers and
// the reachability search registers of the guarded transition table.
// ----------------------------------------------------------------------------
module gtt_datapath #(
  parameter int unsigned MAX_STATES = gtt_pkg::MAX_STATES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gtt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gtt_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  gtt_pkg::gtt_item_t               item_i,
  input  gtt_pkg::gtt_ctrl_t               ctrl_i,
  output gtt_pkg::gtt_stat_t               stat_o,
  output gtt_pkg::gtt_result_t             res_o,
  output logic                             done_o
);

  localparam int unsigned IDX_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam logic [gtt_pkg::CNT_W-1:0] MAX_N = gtt_pkg::CNT_W'(MAX_STATES);
  localparam logic [MAX_STATES-1:0] ONE_HOT0 = MAX_STATES'(1);

  // configuration
  logic [gtt_pkg::CNT_W-1:0]   state_count_q;
  logic [gtt_pkg::STATE_W-1:0] initial_state_q;

  // latched item
  gtt_pkg::gtt_item_t item_q;

  // permission matrix and its read port
  logic [gtt_pkg::ROW_W-1:0] mem_q [MAX_STATES];
  logic [MAX_STATES-1:0]     valid_q;
  logic [gtt_pkg::ROW_W-1:0] rd_data_q;
  logic                      rd_valid_q;
  logic [IDX_W-1:0]          rd_addr;
  logic                      wr_en;

  // architectural state
  logic [gtt_pkg::STATE_W-1:0] state_now_q, state_now_d;
  logic [gtt_pkg::TOT_W-1:0]   moves_q, moves_d;
  logic [gtt_pkg::TOT_W-1:0]   refused_q, refused_d;
  gtt_pkg::gtt_status_e        status_d;

  // search registers
  logic [MAX_STATES-1:0]     pending_q, expanded_q, reached_q;
  logic [MAX_STATES-1:0]     expanded_d, lowest;
  logic [IDX_W-1:0]          node_q, node_pick;
  logic                      first_q;
  logic                      may_q;
  logic [gtt_pkg::ROW_W-1:0] mask_q;

  // result
  gtt_pkg::gtt_result_t res_q, res_d;
  logic                 done_q;

  // decoded values
  logic [gtt_pkg::CNT_W-1:0] eff_n;
  logic [gtt_pkg::ROW_W-1:0] low_mask, row_data, row_now;
  logic [MAX_STATES-1:0]     row_small;
  logic                      from_ok, to_ok, init_ok, cur_ok;

  // effective state count and range checks
  always_comb begin
    eff_n   = (state_count_q > MAX_N) ? MAX_N : state_count_q;
    from_ok = {1'b0, item_q.from_state} < eff_n;
    to_ok   = {1'b0, item_q.to_state} < eff_n;
    init_ok = {1'b0, initial_state_q} < eff_n;
    cur_ok  = {1'b0, state_now_q} < eff_n;
    for (int i = 0; i < gtt_pkg::ROW_W; i++) begin
      low_mask[i] = gtt_pkg::CNT_W'(i) < eff_n;
    end
  end

  // row read from the matrix, empty where never loaded
  assign row_data  = rd_valid_q ? (rd_data_q & low_mask) : '0;
  assign row_now   = cur_ok ? row_data : '0;
  assign row_small = row_data[MAX_STATES-1:0];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_count_q   <= gtt_pkg::STATE_COUNT_RST;
      initial_state_q <= gtt_pkg::INITIAL_STATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gtt_pkg::REG_STATE_COUNT:   state_count_q   <= cfg_wdata_i[gtt_pkg::CNT_W-1:0];
        gtt_pkg::REG_INITIAL_STATE: initial_state_q <= cfg_wdata_i[gtt_pkg::STATE_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture on transfer
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) item_q <= item_i;
  end

  // read address select
  always_comb begin
    case (ctrl_i.rd_sel)
      gtt_pkg::RD_CUR:  rd_addr = state_now_q[IDX_W-1:0];
      gtt_pkg::RD_FROM: rd_addr = item_q.from_state[IDX_W-1:0];
      gtt_pkg::RD_NODE: rd_addr = node_pick;
      default:          rd_addr = state_now_q[IDX_W-1:0];
    endcase
  end

  // matrix storage, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[item_q.from_state[IDX_W-1:0]] <= item_q.row_bits;
    rd_data_q <= mem_q[rd_addr];
  end

  // row valid flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) valid_q[item_q.from_state[IDX_W-1:0]] <= 1'b1;
      rd_valid_q <= valid_q[rd_addr];
    end
  end

  // command execution
  always_comb begin
    state_now_d = state_now_q;
    moves_d     = moves_q;
    refused_d   = refused_q;
    status_d    = gtt_pkg::STAT_OK;
    wr_en       = 1'b0;
    if (ctrl_i.exec) begin
      case (item_q.cmd)
        gtt_pkg::CMD_LOAD: begin
          if (!from_ok) status_d = gtt_pkg::STAT_RANGE;
          else wr_en = 1'b1;
        end
        gtt_pkg::CMD_RESTART: begin
          if (!init_ok) begin
            status_d = gtt_pkg::STAT_RANGE;
          end else begin
            state_now_d = initial_state_q;
            moves_d     = '0;
            refused_d   = '0;
          end
        end
        gtt_pkg::CMD_GO: begin
          if (!to_ok) begin
            status_d = gtt_pkg::STAT_RANGE;
          end else if (!row_now[item_q.to_state]) begin
            status_d  = gtt_pkg::STAT_REFUSED;
            refused_d = refused_q + 1'b1;
          end else begin
            state_now_d = item_q.to_state;
            moves_d     = moves_q + 1'b1;
          end
        end
        gtt_pkg::CMD_FORCE: begin
          if (!to_ok) begin
            status_d = gtt_pkg::STAT_RANGE;
          end else begin
            state_now_d = item_q.to_state;
            moves_d     = moves_q + 1'b1;
          end
        end
        gtt_pkg::CMD_QUERY: begin
          if (!(from_ok && to_ok)) status_d = gtt_pkg::STAT_RANGE;
        end
        default: ;
      endcase
    end
  end

  assign stat_o.query_ok      = (item_q.cmd == gtt_pkg::CMD_QUERY) && from_ok && to_ok;
  assign stat_o.pending_empty = (pending_q == '0);

  // architectural state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_now_q <= '0;
      moves_q     <= '0;
      refused_q   <= '0;
      done_q      <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      state_now_q <= state_now_d;
      moves_q     <= moves_d;
      refused_q   <= refused_d;
      done_q      <= ctrl_i.emit;
      if (ctrl_i.q_init) first_q <= 1'b1;
      else if (ctrl_i.q_step) first_q <= 1'b0;
    end
  end

  // lowest pending node
  always_comb begin
    lowest    = pending_q & (~pending_q + ONE_HOT0);
    node_pick = '0;
    for (int i = 0; i < MAX_STATES; i++) begin
      if (lowest[i]) node_pick = node_pick | IDX_W'(i);
    end
  end

  assign expanded_d = expanded_q | (ONE_HOT0 << node_q);

  // reachability search, one row per step
  always_ff @(posedge clk_i) begin
    if (ctrl_i.q_init) begin
      may_q      <= row_now[item_q.to_state];
      pending_q  <= ONE_HOT0 << item_q.from_state[IDX_W-1:0];
      expanded_q <= '0;
      reached_q  <= '0;
      node_q     <= item_q.from_state[IDX_W-1:0];
    end
    if (ctrl_i.q_step) begin
      expanded_q <= expanded_d;
      reached_q  <= reached_q | row_small;
      pending_q  <= (pending_q | row_small) & ~expanded_d;
      if (first_q) mask_q <= row_data;
    end
    if (ctrl_i.q_pick) node_q <= node_pick;
  end

  // result assembly
  always_comb begin
    res_d                  = '0;
    res_d.status           = status_d;
    res_d.current_state    = state_now_d;
    res_d.transition_total = moves_d;
    res_d.refusal_total    = refused_d;
    if (!ctrl_i.exec) begin
      res_d.may_go         = may_q;
      res_d.row_mask       = mask_q;
      res_d.is_terminal    = (mask_q == '0);
      res_d.reachable_flag = reached_q[item_q.to_state[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) res_q <= res_d;
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

// File: design/gtt_checker.sv
// ----------------------------------------------------------------------------
// gtt_checker
// Port-level checks of the guarded transition table, bound to the top level.
// ----------------------------------------------------------------------------
`include "guarded_transition_table_macros.svh"

module gtt_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input gtt_pkg::gtt_result_t res_o,
  input logic                 done_o
);

  // a transfer always occupies the block in the next cycle
  `GTT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, (start && !busy), busy)

  // every command is latched in IDLE and executed in EXEC before its strobe, so strobes never abut
  `GTT_ASSERT_NEXT(a_done_gap, clk_i, rst_ni, done_o, !done_o)

  // a result is shown while the block is ready for the next transfer
  `GTT_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_o, !busy)

  // query fields stay clear on any failed command
  `GTT_ASSERT_IMPL(a_err_fields, clk_i, rst_ni,
    (done_o && (res_o.status != gtt_pkg::STAT_OK)),
    (!res_o.may_go && (res_o.row_mask == '0) && !res_o.is_terminal &&
     !res_o.reachable_flag))

endmodule

bind guarded_transition_table gtt_checker u_gtt_checker (.*);
